// ----- rtl/core/rsc_pkg.sv -----
// shared types and constants of the receiver sequence check
// no dependencies
package rsc_pkg;

    localparam logic [2:0] V_ACK        = 3'd0;
    localparam logic [2:0] V_NACK       = 3'd1;
    localparam logic [2:0] V_INORDER    = 3'd2;
    localparam logic [2:0] V_DUP        = 3'd3;
    localparam logic [2:0] V_SUPPRESSED = 3'd4;

    localparam logic [3:0] CFG_ACK_INTERVAL  = 4'd0;
    localparam logic [3:0] CFG_CHUNK_SIZE    = 4'd1;
    localparam logic [3:0] CFG_BACK_TO_ZERO  = 4'd2;
    localparam logic [3:0] CFG_NACK_INTERVAL = 4'd3;

    localparam logic [31:0] NACK_INTERVAL_RST = 32'd500000;

    typedef struct packed {
        logic [31:0] ack_interval;
        logic [31:0] chunk_size;
        logic        back_to_zero;
        logic [31:0] nack_interval;
    } t_cfg;

    typedef struct packed {
        logic [31:0] seq;
        logic [15:0] len;
        logic        mark;
        logic [47:0] now;
    } t_item;

    typedef struct packed {
        logic [31:0] next_exp;
        logic [47:0] deadline;
        logic [31:0] last_nacked;
        logic [15:0] ident;
    } t_entry;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [31:0] ack_seq;
        logic        mark;
        logic [15:0] ident;
    } t_result;

endpackage

// ----- rtl/core/rsc_front.sv -----
// front part: takes requests, reduces the flow index, two-entry queue
// depends on rsc_pkg
module rsc_front #(
    parameter int FLOWS = 256,
    parameter int IW    = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_flow_index,
    input  rsc_pkg::t_item       i_item,
    input  logic                 i_pop,
    output logic                 o_nonempty,
    output logic [IW-1:0]        o_head_idx,
    output rsc_pkg::t_item       o_head
);
    import rsc_pkg::*;

    t_item         r_q   [2];
    logic [IW-1:0] r_qi  [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          push;
    logic [IW-1:0] flow_mod;

    // flow index folded onto the table, a constant lookup over all 256 codes
    always_comb begin
        flow_mod = '0;
        for (int k = 0; k < 256; k++) begin
            if (i_flow_index == 8'(k)) flow_mod = IW'(k % FLOWS);
        end
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_nonempty = (r_cnt != 2'd0);
    assign o_head     = r_q[r_rp];
    assign o_head_idx = r_qi[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp]  <= i_item;
            r_qi[r_wp] <= flow_mod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule

// ----- rtl/core/rsc_div.sv -----
// radix-2 restoring remainder unit, one bit per cycle
// depends on rsc_pkg only through house style
module rsc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic [31:0] o_rem
);
    logic [32:0] r_rem;
    logic [31:0] r_dvd, r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] sh;

    assign sh     = {r_rem[31:0], r_dvd[31]};
    assign o_busy = r_busy;
    assign o_rem  = r_rem[31:0];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 33'd0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= (sh >= {1'b0, r_dvs}) ? sh - {1'b0, r_dvs} : sh;
            r_dvd <= {r_dvd[30:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 6'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd32;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_busy <= 1'b0;
        end
    end

endmodule

// ----- rtl/core/rsc_back.sv -----
// back part: flow table, classification, remainder step, write-back and result register
// depends on rsc_pkg and rsc_div
module rsc_back #(
    parameter int FLOWS = 256,
    parameter int IW    = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rsc_pkg::t_cfg        i_cfg,
    input  logic                 i_nonempty,
    input  logic [IW-1:0]        i_head_idx,
    input  rsc_pkg::t_item       i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rsc_pkg::t_result     o_res
);
    import rsc_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    t_entry        mem [FLOWS];
    t_entry        r_rd;
    t_item         r_item;
    logic [IW-1:0] r_idx, r_clr;
    logic [2:0]    r_verdict;
    logic          r_ge, r_use_div;
    t_result       r_res;
    logic          r_out_valid;

    logic          mem_we;
    logic [IW-1:0] waddr;
    t_entry        wdata;
    logic          div_start, div_busy;
    logic [31:0]   div_dvd, div_rem;
    logic [31:0]   exp, upd;
    logic          load;
    logic [2:0]    fin_verdict;
    logic [31:0]   fin_exp;
    logic          sent;

    assign exp   = r_rd.next_exp;
    assign upd   = exp + 32'(r_item.len);
    assign o_pop = (r_state == S_IDLE) && i_nonempty;
    assign load  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    rsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (i_cfg.chunk_size),
        .o_busy     (div_busy),
        .o_rem      (div_rem)
    );

    // decide at read time whether a remainder is needed
    always_comb begin
        div_start = 1'b0;
        div_dvd   = upd;
        if (r_state == S_READ) begin
            if (r_item.seq == exp) begin
                div_start = (i_cfg.chunk_size != 32'd0);
            end else if (r_item.seq > exp) begin
                div_dvd   = exp;
                div_start = (r_item.now >= r_rd.deadline || r_rd.last_nacked != exp)
                            && i_cfg.back_to_zero && (i_cfg.chunk_size != 32'd0);
            end
        end
    end

    always_comb begin
        fin_verdict = r_verdict;
        fin_exp     = r_rd.next_exp;
        if (r_verdict == V_INORDER) begin
            fin_exp = upd;
            if (r_ge || (r_use_div && div_rem == 32'd0)) fin_verdict = V_ACK;
        end else if (r_verdict == V_NACK && r_use_div) begin
            fin_exp = exp - div_rem;
        end
        sent = (fin_verdict == V_ACK) || (fin_verdict == V_NACK);
    end

    always_comb begin
        mem_we = 1'b0;
        waddr  = r_idx;
        wdata  = r_rd;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
            waddr  = r_clr;
            wdata  = '0;
        end else if (load) begin
            mem_we         = 1'b1;
            wdata.next_exp = fin_exp;
            if (fin_verdict == V_NACK) begin
                wdata.deadline    = r_item.now + 48'(i_cfg.nack_interval);
                wdata.last_nacked = exp;
            end
            if (sent) wdata.ident = r_rd.ident + 16'd1;
        end
    end

    // entry is held from the pop until its write-back
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[waddr] <= wdata;
        if (o_pop) r_rd <= mem[i_head_idx];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
            r_idx  <= i_head_idx;
        end
        if (r_state == S_READ) begin
            r_ge      <= (upd >= i_cfg.ack_interval);
            r_use_div <= div_start;
            if (r_item.seq == exp)
                r_verdict <= V_INORDER;
            else if (r_item.seq > exp)
                r_verdict <= (r_item.now >= r_rd.deadline || r_rd.last_nacked != exp)
                             ? V_NACK : V_SUPPRESSED;
            else
                r_verdict <= V_DUP;
        end
        if (load) begin
            r_res.verdict <= fin_verdict;
            r_res.ack_seq <= fin_exp;
            r_res.mark    <= r_item.mark;
            r_res.ident   <= sent ? r_rd.ident : 16'd0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == IW'(FLOWS - 1)) n_state = S_IDLE;
            S_IDLE:  if (i_nonempty) n_state = S_READ;
            S_READ:  n_state = div_start ? S_DIV : S_DONE;
            S_DIV:   if (!div_busy) n_state = S_DONE;
            S_DONE:  if (load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + IW'(1);
            if (load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

// ----- rtl/core/rdma_receiver_seq_check.sv -----
// go-back-n receiver: per-flow sequence check with ack/nack decision
// verdict registered after table read and classification, plus the divider when a chunk
// remainder is needed; one request at a time in the back part (32-step divider)
// a two-entry queue in front keeps taking requests while the back part works, until full
// synchronous active-low reset; after reset a clearing pass zeroes the flow table entry by
// entry, at most two requests are queued meanwhile, configuration is taken at once
module rdma_receiver_seq_check #(
    parameter int FLOWS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // packet requests
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_flow_index,
    input  logic [31:0] i_seq_number,
    input  logic [15:0] i_payload_bytes,
    input  logic [1:0]  i_ecn_bits,
    input  logic [47:0] i_now_ns,
    // verdicts
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_verdict,
    output logic [31:0] o_ack_seq,
    output logic        o_congestion_mark,
    output logic [15:0] o_ip_ident
);
    import rsc_pkg::*;

    // table index width, at least one bit for a single flow
    localparam int IW = (FLOWS > 1) ? $clog2(FLOWS) : 1;

    t_cfg          r_cfg;
    t_item         in_item;
    t_item         head;
    logic [IW-1:0] head_idx;
    logic          nonempty, pop;
    t_result       res;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ack_interval  <= 32'd0;
            r_cfg.chunk_size    <= 32'd0;
            r_cfg.back_to_zero  <= 1'b0;
            r_cfg.nack_interval <= NACK_INTERVAL_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ACK_INTERVAL:  r_cfg.ack_interval  <= i_cfg_data;
                CFG_CHUNK_SIZE:    r_cfg.chunk_size    <= i_cfg_data;
                CFG_BACK_TO_ZERO:  r_cfg.back_to_zero  <= i_cfg_data[0];
                CFG_NACK_INTERVAL: r_cfg.nack_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // congestion mark is settled at the front
    assign in_item.seq  = i_seq_number;
    assign in_item.len  = i_payload_bytes;
    assign in_item.mark = (i_ecn_bits != 2'd0);
    assign in_item.now  = i_now_ns;

    rsc_front #(.FLOWS(FLOWS), .IW(IW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_flow_index (i_flow_index),
        .i_item       (in_item),
        .i_pop        (pop),
        .o_nonempty   (nonempty),
        .o_head_idx   (head_idx),
        .o_head       (head)
    );

    // table read-modify-write, remainder unit and result register
    rsc_back #(.FLOWS(FLOWS), .IW(IW)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_nonempty   (nonempty),
        .i_head_idx   (head_idx),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_res        (res)
    );

    assign o_verdict         = res.verdict;
    assign o_ack_seq         = res.ack_seq;
    assign o_congestion_mark = res.mark;
    assign o_ip_ident        = res.ident;

endmodule
